/* hw/rtl/pidta_pkg.sv */
package pidta_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int COEF_FRAC_BITS = 24;

    localparam int ACC_BITS   = 48;
    localparam int LIMB_BITS  = ACC_BITS / 2;
    localparam int ERR_BITS   = SAMPLE_BITS + 1;
    localparam int DE_BITS    = SAMPLE_BITS + 2;
    localparam int COEF_BITS  = 32;
    localparam int UCOEF_BITS = 25;

    localparam int MUL_A_BITS = (LIMB_BITS + 1 > DE_BITS) ? LIMB_BITS + 1 : DE_BITS;
    localparam int MUL_B_BITS = COEF_BITS + 1;
    localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;
    localparam int MQ_BITS    = PROD_BITS + LIMB_BITS;
    localparam int SUM_BITS   = PROD_BITS + 2;

    localparam int IN_DATA_BITS  = ((3 * SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;

    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = COEF_BITS;

    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // Register indexes.
    localparam logic [CFG_ADDR_BITS-1:0] REG_GAIN_K            = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_SETPOINT_WEIGHT   = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_DERIV_POLE        = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_DERIV_GAIN        = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] REG_INTEGRAL_GAIN     = 3'd4;
    localparam logic [CFG_ADDR_BITS-1:0] REG_TRACKING_GAIN     = 3'd5;
    localparam logic [CFG_ADDR_BITS-1:0] REG_INTEGRATOR_ENABLE = 3'd6;

    // Register reset values.
    localparam logic signed [COEF_BITS-1:0] RST_GAIN_K            = -32'sd2013266;
    localparam logic signed [COEF_BITS-1:0] RST_SETPOINT_WEIGHT   = 32'sd16777216;
    localparam logic [UCOEF_BITS-1:0]       RST_DERIV_POLE        = 25'd12117434;
    localparam logic signed [COEF_BITS-1:0] RST_DERIV_GAIN        = -32'sd14540254;
    localparam logic signed [COEF_BITS-1:0] RST_INTEGRAL_GAIN     = -32'sd3300;
    localparam logic [UCOEF_BITS-1:0]       RST_TRACKING_GAIN     = 25'd167772;
    localparam logic                        RST_INTEGRATOR_ENABLE = 1'b0;

    // Multiplier operand selection.
    localparam int MUL_SEL_BITS = 4;
    localparam logic [MUL_SEL_BITS-1:0] MUL_NONE   = 4'd0;
    localparam logic [MUL_SEL_BITS-1:0] MUL_TRK_LO = 4'd1;
    localparam logic [MUL_SEL_BITS-1:0] MUL_TRK_HI = 4'd2;
    localparam logic [MUL_SEL_BITS-1:0] MUL_KI     = 4'd3;
    localparam logic [MUL_SEL_BITS-1:0] MUL_AD_LO  = 4'd4;
    localparam logic [MUL_SEL_BITS-1:0] MUL_AD_HI  = 4'd5;
    localparam logic [MUL_SEL_BITS-1:0] MUL_BD     = 4'd6;
    localparam logic [MUL_SEL_BITS-1:0] MUL_BETA   = 4'd7;
    localparam logic [MUL_SEL_BITS-1:0] MUL_K_LO   = 4'd8;
    localparam logic [MUL_SEL_BITS-1:0] MUL_K_HI   = 4'd9;

    // Product accumulator operations.
    localparam logic [1:0] ACC_HOLD    = 2'd0;
    localparam logic [1:0] ACC_LOAD_LO = 2'd1;
    localparam logic [1:0] ACC_ADD_HI  = 2'd2;

    typedef struct packed {
        logic signed [COEF_BITS-1:0] gain_k;
        logic signed [COEF_BITS-1:0] setpoint_weight;
        logic [UCOEF_BITS-1:0]       deriv_pole;
        logic signed [COEF_BITS-1:0] deriv_gain;
        logic signed [COEF_BITS-1:0] integral_gain;
        logic [UCOEF_BITS-1:0]       tracking_gain;
        logic                        integrator_enable;
    } t_cfg;

    typedef struct packed {
        logic                    load_in;
        logic [MUL_SEL_BITS-1:0] mul_sel;
        logic [1:0]              acc_op;
        logic                    ld_diff;
        logic                    sum_ki;
        logic                    mq_ld;
        logic                    upd_integ;
        logic                    sum_bd;
        logic                    upd_deriv;
        logic                    sum_id;
        logic                    upd_last;
        logic                    ld_out;
    } t_cmd;

endpackage

/* hw/rtl/pid_controller_tracking_antiwindup.sv */
// PID controller with set-point weighting, filtered derivative and tracking
// anti-windup in Q8.24 fixed point. Under a step sequencer, nine partial
// products go one per cycle through a single shared 25 by 33 bit
// multiplier, followed by the rounding and saturating adds. A new sample
// is accepted as soon as the previous one has moved into the output
// register, so no new sample is taken while one is in flight.
// Coefficients are to be written through the configuration port only while
// no sample is in flight; the block itself does not enforce this. A write
// to an index beyond the last register is ignored.
module pid_controller_tracking_antiwindup (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // Fields from bit 0: measured, reference, applied_drive.
    input  logic [pidta_pkg::IN_DATA_BITS-1:0]    s_axis_tdata,
    // Fields from bit 0: clear_integral.
    input  logic [0:0]                            s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // Fields from bit 0: control_out, then zero padding.
    output logic [pidta_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata,
    // Fields from bit 0: out_saturated.
    output logic [0:0]                            m_axis_tuser,
    input  logic                                  i_cfg_we,
    input  logic [pidta_pkg::CFG_ADDR_BITS-1:0]   i_cfg_addr,
    input  logic [pidta_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);
    import pidta_pkg::*;

    t_cfg                          cfg;
    t_cmd                          cmd;
    logic signed [SAMPLE_BITS-1:0] control_out;
    logic                          out_saturated;

    pidta_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    pidta_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd)
    );

    pidta_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_cfg            (cfg),
        .i_measured       ($signed(s_axis_tdata[SAMPLE_BITS-1:0])),
        .i_reference      ($signed(s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS])),
        .i_applied_drive  ($signed(s_axis_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS])),
        .i_clear_integral (s_axis_tuser[0]),
        .o_control_out    (control_out),
        .o_out_saturated  (out_saturated)
    );

    assign m_axis_tdata    = OUT_DATA_BITS'(unsigned'(control_out));
    assign m_axis_tuser[0] = out_saturated;

endmodule

/* hw/rtl/pidta_cfg.sv */
module pidta_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [pidta_pkg::CFG_ADDR_BITS-1:0] i_cfg_addr,
    input  logic [pidta_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    output pidta_pkg::t_cfg                     o_cfg
);
    import pidta_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_GAIN_K:            n_cfg.gain_k = $signed(i_cfg_data[COEF_BITS-1:0]);
                REG_SETPOINT_WEIGHT:
                    n_cfg.setpoint_weight = $signed(i_cfg_data[COEF_BITS-1:0]);
                REG_DERIV_POLE:        n_cfg.deriv_pole = i_cfg_data[UCOEF_BITS-1:0];
                REG_DERIV_GAIN:        n_cfg.deriv_gain = $signed(i_cfg_data[COEF_BITS-1:0]);
                REG_INTEGRAL_GAIN:
                    n_cfg.integral_gain = $signed(i_cfg_data[COEF_BITS-1:0]);
                REG_TRACKING_GAIN:     n_cfg.tracking_gain = i_cfg_data[UCOEF_BITS-1:0];
                REG_INTEGRATOR_ENABLE: n_cfg.integrator_enable = i_cfg_data[0];
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_k            <= RST_GAIN_K;
            r_cfg.setpoint_weight   <= RST_SETPOINT_WEIGHT;
            r_cfg.deriv_pole        <= RST_DERIV_POLE;
            r_cfg.deriv_gain        <= RST_DERIV_GAIN;
            r_cfg.integral_gain     <= RST_INTEGRAL_GAIN;
            r_cfg.tracking_gain     <= RST_TRACKING_GAIN;
            r_cfg.integrator_enable <= RST_INTEGRATOR_ENABLE;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* hw/rtl/pidta_ctrl.sv */
module pidta_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output pidta_pkg::t_cmd o_cmd
);
    import pidta_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    localparam logic [3:0] STEP_DIFF   = 4'd0;
    localparam logic [3:0] STEP_TRK_LO = 4'd1;
    localparam logic [3:0] STEP_TRK_HI = 4'd2;
    localparam logic [3:0] STEP_KI     = 4'd3;
    localparam logic [3:0] STEP_AD_LO  = 4'd4;
    localparam logic [3:0] STEP_AD_HI  = 4'd5;
    localparam logic [3:0] STEP_BD     = 4'd6;
    localparam logic [3:0] STEP_BETA   = 4'd7;
    localparam logic [3:0] STEP_DERIV  = 4'd8;
    localparam logic [3:0] STEP_K_LO   = 4'd9;
    localparam logic [3:0] STEP_K_HI   = 4'd10;
    localparam logic [3:0] STEP_K_ADD  = 4'd11;
    localparam logic [3:0] STEP_SUM    = 4'd12;
    localparam logic [3:0] STEP_LAST   = 4'd13;
    localparam logic [3:0] STEP_OUT    = 4'd14;

    logic       r_state;
    logic       n_state;
    logic [3:0] r_step;
    logic [3:0] n_step;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       in_ready;
    t_cmd       cmd;

    assign in_ready = (r_state == ST_IDLE) && i_rst_n;

    always_comb begin
        cmd         = '0;
        n_state     = r_state;
        n_step      = r_step;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid && in_ready) begin
                    cmd.load_in = 1'b1;
                    n_state     = ST_RUN;
                    n_step      = STEP_DIFF;
                end
            end
            ST_RUN: begin
                n_step = r_step + 4'd1;
                unique case (r_step)
                    STEP_DIFF:   cmd.ld_diff = 1'b1;
                    STEP_TRK_LO: cmd.mul_sel = MUL_TRK_LO;
                    STEP_TRK_HI: begin
                        cmd.mul_sel = MUL_TRK_HI;
                        cmd.acc_op  = ACC_LOAD_LO;
                    end
                    STEP_KI: begin
                        cmd.mul_sel = MUL_KI;
                        cmd.acc_op  = ACC_ADD_HI;
                    end
                    STEP_AD_LO: begin
                        cmd.mul_sel = MUL_AD_LO;
                        cmd.sum_ki  = 1'b1;
                        cmd.mq_ld   = 1'b1;
                    end
                    STEP_AD_HI: begin
                        cmd.mul_sel   = MUL_AD_HI;
                        cmd.acc_op    = ACC_LOAD_LO;
                        cmd.upd_integ = 1'b1;
                    end
                    STEP_BD: begin
                        cmd.mul_sel = MUL_BD;
                        cmd.acc_op  = ACC_ADD_HI;
                    end
                    STEP_BETA: begin
                        cmd.mul_sel = MUL_BETA;
                        cmd.sum_bd  = 1'b1;
                        cmd.mq_ld   = 1'b1;
                    end
                    STEP_DERIV: cmd.upd_deriv = 1'b1;
                    STEP_K_LO:  cmd.mul_sel = MUL_K_LO;
                    STEP_K_HI: begin
                        cmd.mul_sel = MUL_K_HI;
                        cmd.acc_op  = ACC_LOAD_LO;
                    end
                    STEP_K_ADD: cmd.acc_op = ACC_ADD_HI;
                    STEP_SUM: begin
                        cmd.sum_id = 1'b1;
                        cmd.mq_ld  = 1'b1;
                    end
                    STEP_LAST: cmd.upd_last = 1'b1;
                    STEP_OUT: begin
                        if (!r_out_valid || i_out_ready) begin
                            cmd.ld_out  = 1'b1;
                            n_out_valid = 1'b1;
                            n_state     = ST_IDLE;
                        end else begin
                            n_step = r_step;
                        end
                    end
                    default: n_state = ST_IDLE;
                endcase
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= STEP_DIFF;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = in_ready;
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

/* hw/rtl/pidta_dp.sv */
module pidta_dp (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  pidta_pkg::t_cmd                          i_cmd,
    input  pidta_pkg::t_cfg                          i_cfg,
    input  logic signed [pidta_pkg::SAMPLE_BITS-1:0] i_measured,
    input  logic signed [pidta_pkg::SAMPLE_BITS-1:0] i_reference,
    input  logic signed [pidta_pkg::SAMPLE_BITS-1:0] i_applied_drive,
    input  logic                                     i_clear_integral,
    output logic signed [pidta_pkg::SAMPLE_BITS-1:0] o_control_out,
    output logic                                     o_out_saturated
);
    import pidta_pkg::*;

    localparam int OUT_HI_BITS = SUM_BITS - COEF_FRAC_BITS - SAMPLE_BITS + 1;
    localparam int MQ_HI_BITS  = MQ_BITS - COEF_FRAC_BITS - ACC_BITS + 1;
    localparam logic signed [MQ_BITS-1:0]  MQ_HALF  =
        {{(MQ_BITS-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);
    localparam logic signed [SUM_BITS-1:0] OUT_HALF =
        {{(SUM_BITS-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);

    function automatic logic signed [ACC_BITS-1:0] sat_acc(
        input logic signed [SUM_BITS-1:0] x
    );
        logic [SUM_BITS-ACC_BITS:0] hi_bits;
        hi_bits = x[SUM_BITS-1:ACC_BITS-1];
        if (hi_bits == '0 || hi_bits == '1) begin
            return x[ACC_BITS-1:0];
        end else if (x[SUM_BITS-1]) begin
            return {1'b1, {(ACC_BITS-1){1'b0}}};
        end else begin
            return {1'b0, {(ACC_BITS-1){1'b1}}};
        end
    endfunction

    // Rounds half up at the coefficient point and saturates to the state width.
    function automatic logic signed [ACC_BITS-1:0] rnd_sat(
        input logic signed [MQ_BITS-1:0] a
    );
        logic signed [MQ_BITS-1:0] x;
        logic [MQ_HI_BITS-1:0]     hi_bits;
        x       = a + MQ_HALF;
        hi_bits = x[MQ_BITS-1:COEF_FRAC_BITS+ACC_BITS-1];
        if (hi_bits == '0 || hi_bits == '1) begin
            return x[COEF_FRAC_BITS+ACC_BITS-1:COEF_FRAC_BITS];
        end else if (x[MQ_BITS-1]) begin
            return {1'b1, {(ACC_BITS-1){1'b0}}};
        end else begin
            return {1'b0, {(ACC_BITS-1){1'b1}}};
        end
    endfunction

    logic signed [SAMPLE_BITS-1:0] r_meas;
    logic signed [SAMPLE_BITS-1:0] r_ref;
    logic signed [SAMPLE_BITS-1:0] r_drive;
    logic                          r_clear;
    logic signed [ACC_BITS-1:0]    r_integ;
    logic signed [ACC_BITS-1:0]    r_deriv;
    logic signed [ACC_BITS-1:0]    r_last;
    logic signed [ERR_BITS-1:0]    r_prev_err;
    logic signed [ACC_BITS-1:0]    r_tmp;
    logic signed [PROD_BITS-1:0]   r_prod;
    logic signed [MQ_BITS-1:0]     r_acc;
    logic signed [SUM_BITS-1:0]    r_sum;
    logic signed [ACC_BITS-1:0]    r_mq;
    logic signed [SAMPLE_BITS-1:0] r_out;
    logic                          r_sat;

    logic signed [ERR_BITS-1:0]    err;
    logic signed [DE_BITS-1:0]     derr;
    logic signed [MUL_A_BITS-1:0]  a_op;
    logic signed [MUL_B_BITS-1:0]  b_op;
    logic signed [MUL_A_BITS-1:0]  tmp_lo;
    logic signed [MUL_A_BITS-1:0]  tmp_hi;
    logic signed [MUL_A_BITS-1:0]  der_lo;
    logic signed [MUL_A_BITS-1:0]  der_hi;
    logic signed [ACC_BITS-1:0]    diff_val;
    logic signed [ACC_BITS-1:0]    w_val;
    logic signed [SUM_BITS-1:0]    out_x;
    logic [OUT_HI_BITS-1:0]        out_hi;
    logic signed [SAMPLE_BITS-1:0] out_val;
    logic                          out_sat;

    assign err  = ERR_BITS'(r_ref) - ERR_BITS'(r_meas);
    assign derr = DE_BITS'(err) - DE_BITS'(r_prev_err);

    assign tmp_lo = MUL_A_BITS'($signed({1'b0, r_tmp[LIMB_BITS-1:0]}));
    assign tmp_hi = MUL_A_BITS'($signed(r_tmp[ACC_BITS-1:LIMB_BITS]));
    assign der_lo = MUL_A_BITS'($signed({1'b0, r_deriv[LIMB_BITS-1:0]}));
    assign der_hi = MUL_A_BITS'($signed(r_deriv[ACC_BITS-1:LIMB_BITS]));

    always_comb begin
        a_op = '0;
        b_op = '0;
        unique case (i_cmd.mul_sel)
            MUL_TRK_LO: begin
                a_op = tmp_lo;
                b_op = MUL_B_BITS'($signed({1'b0, i_cfg.tracking_gain}));
            end
            MUL_TRK_HI: begin
                a_op = tmp_hi;
                b_op = MUL_B_BITS'($signed({1'b0, i_cfg.tracking_gain}));
            end
            MUL_KI: begin
                a_op = MUL_A_BITS'(r_prev_err);
                b_op = MUL_B_BITS'($signed(i_cfg.integral_gain));
            end
            MUL_AD_LO: begin
                a_op = der_lo;
                b_op = MUL_B_BITS'($signed({1'b0, i_cfg.deriv_pole}));
            end
            MUL_AD_HI: begin
                a_op = der_hi;
                b_op = MUL_B_BITS'($signed({1'b0, i_cfg.deriv_pole}));
            end
            MUL_BD: begin
                a_op = MUL_A_BITS'(derr);
                b_op = MUL_B_BITS'($signed(i_cfg.deriv_gain));
            end
            MUL_BETA: begin
                a_op = MUL_A_BITS'(r_ref);
                b_op = MUL_B_BITS'($signed(i_cfg.setpoint_weight));
            end
            MUL_K_LO: begin
                a_op = tmp_lo;
                b_op = MUL_B_BITS'($signed(i_cfg.gain_k));
            end
            MUL_K_HI: begin
                a_op = tmp_hi;
                b_op = MUL_B_BITS'($signed(i_cfg.gain_k));
            end
            default: begin
                a_op = '0;
                b_op = '0;
            end
        endcase
    end

    assign diff_val = sat_acc((SUM_BITS'(r_drive) <<< COEF_FRAC_BITS) - SUM_BITS'(r_last));
    assign w_val    = sat_acc(SUM_BITS'(r_prod) - (SUM_BITS'(r_meas) <<< COEF_FRAC_BITS));

    assign out_x  = SUM_BITS'(r_last) + OUT_HALF;
    assign out_hi = out_x[SUM_BITS-1:COEF_FRAC_BITS+SAMPLE_BITS-1];

    always_comb begin
        if (out_hi == '0 || out_hi == '1) begin
            out_val = out_x[COEF_FRAC_BITS+SAMPLE_BITS-1:COEF_FRAC_BITS];
            out_sat = 1'b0;
        end else begin
            out_val = out_x[SUM_BITS-1] ? $signed(SAMPLE_MIN) : $signed(SAMPLE_MAX);
            out_sat = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= a_op * b_op;
        if (i_cmd.load_in) begin
            r_meas  <= i_measured;
            r_ref   <= i_reference;
            r_drive <= i_applied_drive;
            r_clear <= i_clear_integral;
        end
        unique case (i_cmd.acc_op)
            ACC_LOAD_LO: r_acc <= MQ_BITS'(r_prod);
            ACC_ADD_HI:  r_acc <= r_acc + (MQ_BITS'(r_prod) <<< LIMB_BITS);
            default:     r_acc <= r_acc;
        endcase
        if (i_cmd.ld_diff) begin
            r_tmp <= diff_val;
        end else if (i_cmd.upd_deriv) begin
            r_tmp <= w_val;
        end
        if (i_cmd.mq_ld) begin
            r_mq <= rnd_sat(r_acc);
        end
        if (i_cmd.sum_ki) begin
            r_sum <= SUM_BITS'(r_integ) + SUM_BITS'(r_prod);
        end else if (i_cmd.sum_bd) begin
            r_sum <= SUM_BITS'(r_prod);
        end else if (i_cmd.sum_id) begin
            r_sum <= SUM_BITS'(r_integ) + SUM_BITS'(r_deriv);
        end
        if (i_cmd.ld_out) begin
            r_out <= out_val;
            r_sat <= out_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ    <= '0;
            r_deriv    <= '0;
            r_last     <= '0;
            r_prev_err <= '0;
        end else begin
            if (i_cmd.upd_integ) begin
                if (i_cfg.integrator_enable && !r_clear) begin
                    r_integ <= sat_acc(r_sum + SUM_BITS'(r_mq));
                end else begin
                    r_integ <= '0;
                end
            end
            if (i_cmd.upd_deriv) begin
                r_deriv    <= sat_acc(r_sum + SUM_BITS'(r_mq));
                r_prev_err <= err;
            end
            if (i_cmd.upd_last) begin
                r_last <= sat_acc(r_sum + SUM_BITS'(r_mq));
            end
        end
    end

    assign o_control_out   = r_out;
    assign o_out_saturated = r_sat;

endmodule

/* hw/rtl/pidta_chk.sv */
module pidta_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                s_axis_tvalid,
    input logic                                s_axis_tready,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [pidta_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,
    input logic [0:0]                          m_axis_tuser
);
    import pidta_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled output word changed or dropped");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted again while a sample is in flight");

    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |->
            m_axis_tdata[SAMPLE_BITS-1:0] == SAMPLE_MAX ||
            m_axis_tdata[SAMPLE_BITS-1:0] == SAMPLE_MIN)
        else $error("saturation flag set on an output inside the range");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output word present right after reset");

endmodule

bind pid_controller_tracking_antiwindup pidta_chk u_pidta_chk (.*);

/* tb/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pidta_pkg::*;

    typedef logic signed [95:0]            t_wide;
    typedef logic signed [SAMPLE_BITS-1:0] t_sample16;

    typedef struct {
        t_sample16 meas;
        t_sample16 refv;
        t_sample16 drive;
        bit        clr;
    } t_sample;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] ctrl;
        logic                   sat;
    } t_ctrl_result;

    typedef enum logic {ROW_WRITE, ROW_SAMPLE} t_row_kind;

    typedef struct {
        t_row_kind                kind;
        logic [CFG_ADDR_BITS-1:0] addr;
        logic [CFG_DATA_BITS-1:0] data;
        t_sample                  smp;
        bit                       typed;
        t_ctrl_result             want;
    } t_row;

    localparam logic [CFG_ADDR_BITS-1:0] REG_UNUSED = 3'd7;

    localparam int    FRAC         = COEF_FRAC_BITS;
    localparam int    S_MAX        = (1 << (SAMPLE_BITS - 1)) - 1;
    localparam int    S_MIN        = -(1 << (SAMPLE_BITS - 1));
    localparam t_wide MAX48        = (t_wide'(1) <<< (ACC_BITS - 1)) - 1;
    localparam t_wide MIN48        = -(t_wide'(1) <<< (ACC_BITS - 1));
    localparam t_wide HALF         = t_wide'(1) <<< (FRAC - 1);
    localparam int    IDLE_CYCLES  = 32;
    localparam int    HOLD_CYCLES  = 400;
    localparam int    CYCLE_LIMIT  = 500000;
    localparam int    PHASES       = 16;
    localparam int    PHASE_WORDS  = 100;
    localparam int    MAX_PRINTS   = 40;

    logic                     i_clk         = 1'b0;
    logic                     i_rst_n       = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [IN_DATA_BITS-1:0]  s_axis_tdata  = '0;
    logic [0:0]               s_axis_tuser  = '0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_axis_tdata;
    logic [0:0]               m_axis_tuser;
    logic                     i_cfg_we      = 1'b0;
    logic [CFG_ADDR_BITS-1:0] i_cfg_addr    = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data    = '0;

    pid_controller_tracking_antiwindup u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Controller coefficients and state as the block should hold them.
    t_wide gain_k     = t_wide'(RST_GAIN_K);
    t_wide sp_weight  = t_wide'(RST_SETPOINT_WEIGHT);
    t_wide d_pole     = t_wide'(RST_DERIV_POLE);
    t_wide d_gain     = t_wide'(RST_DERIV_GAIN);
    t_wide i_gain     = t_wide'(RST_INTEGRAL_GAIN);
    t_wide trk_gain   = t_wide'(RST_TRACKING_GAIN);
    bit    integ_on   = RST_INTEGRATOR_ENABLE;
    t_wide integ_acc  = '0;
    t_wide deriv_acc  = '0;
    t_wide prev_err   = '0;
    t_wide last_v     = '0;

    t_ctrl_result ctrl_outputs_due[$];
    t_row         dir_rows[$];

    int  error_count = 0;
    int  words_seen  = 0;
    int  cycle_count = 0;
    int  src_gap_max = 6;
    int  snk_gap_max = 6;
    bit  cfg_open    = 1'b0;
    int  ref_level   = 0;
    int  meas_level  = 0;
    int  last_ctrl   = 0;
    int  act_lim     = S_MAX;

    function automatic t_wide sat48(t_wide x);
        if (x > MAX48) return MAX48;
        if (x < MIN48) return MIN48;
        return x;
    endfunction

    function automatic t_wide mul_q(t_wide a, t_wide k);
        return sat48((a * k + HALF) >>> FRAC);
    endfunction

    function automatic void cfg_model(logic [CFG_ADDR_BITS-1:0] idx,
                                      logic [CFG_DATA_BITS-1:0] d);
        case (idx)
            REG_GAIN_K:            gain_k    = t_wide'($signed(d));
            REG_SETPOINT_WEIGHT:   sp_weight = t_wide'($signed(d));
            REG_DERIV_POLE:        d_pole    = t_wide'(d[UCOEF_BITS-1:0]);
            REG_DERIV_GAIN:        d_gain    = t_wide'($signed(d));
            REG_INTEGRAL_GAIN:     i_gain    = t_wide'($signed(d));
            REG_TRACKING_GAIN:     trk_gain  = t_wide'(d[UCOEF_BITS-1:0]);
            REG_INTEGRATOR_ENABLE: integ_on  = d[0];
            default: ;
        endcase
    endfunction

    function automatic t_ctrl_result pid_update(t_sample s);
        t_wide        y = t_wide'(s.meas);
        t_wide        r = t_wide'(s.refv);
        t_wide        u = t_wide'(s.drive);
        t_wide        err;
        t_wide        w;
        t_wide        v;
        t_wide        q;
        t_ctrl_result res;
        if (!integ_on || s.clr) begin
            integ_acc = '0;
        end else begin
            integ_acc = sat48(integ_acc + i_gain * prev_err
                              + mul_q(sat48((u <<< FRAC) - last_v), trk_gain));
        end
        err       = r - y;
        deriv_acc = sat48(mul_q(deriv_acc, d_pole) + d_gain * (err - prev_err));
        prev_err  = err;
        w         = sat48(r * sp_weight - (y <<< FRAC));
        v         = sat48(mul_q(w, gain_k) + integ_acc + deriv_acc);
        last_v    = v;
        q         = (v + HALF) >>> FRAC;
        res.sat   = 1'b0;
        if (q > S_MAX) begin
            q       = S_MAX;
            res.sat = 1'b1;
        end
        if (q < S_MIN) begin
            q       = S_MIN;
            res.sat = 1'b1;
        end
        res.ctrl  = q[SAMPLE_BITS-1:0];
        last_ctrl = int'(q);
        return res;
    endfunction

    function automatic int clip_to(int x, int lo, int hi);
        if (x > hi) return hi;
        if (x < lo) return lo;
        return x;
    endfunction

    function automatic t_sample16 rand_sample();
        case ($urandom_range(0, 7))
            0: return t_sample16'(S_MIN);
            1: return t_sample16'(S_MAX);
            2: return t_sample16'(0);
            3: return t_sample16'(-1);
            default: return t_sample16'($urandom);
        endcase
    endfunction

    // Mostly a slowly settling loop around a stepped reference, with the
    // actuator clipping the previous output, plus occasional noise.
    function automatic t_sample next_sample();
        t_sample s;
        if ($urandom_range(0, 11) == 0) ref_level = int'(rand_sample());
        meas_level = clip_to(meas_level + (ref_level - meas_level) / 8
                             + int'($urandom_range(0, 128)) - 64, S_MIN, S_MAX);
        s.refv  = ($urandom_range(0, 15) == 0) ? rand_sample() : t_sample16'(ref_level);
        s.meas  = ($urandom_range(0, 7) == 0) ? rand_sample() : t_sample16'(meas_level);
        if ($urandom_range(0, 9) < 6)
            s.drive = t_sample16'(clip_to(last_ctrl, -act_lim, act_lim));
        else
            s.drive = rand_sample();
        s.clr = ($urandom_range(0, 31) == 0);
        return s;
    endfunction

    function automatic logic [CFG_DATA_BITS-1:0] cfg_pick(logic [CFG_ADDR_BITS-1:0] idx);
        logic [CFG_DATA_BITS-1:0] junk;
        logic [CFG_DATA_BITS-1:0] val;
        int                       pick;
        junk = $urandom;
        pick = $urandom_range(0, 9);
        if (idx == REG_INTEGRATOR_ENABLE)
            return {junk[CFG_DATA_BITS-1:1], pick < 7};
        if (idx == REG_DERIV_POLE || idx == REG_TRACKING_GAIN) begin
            case (pick)
                0: val = '0;
                1: val = 32'd1 << FRAC;
                2: val = '1;
                3: val = (idx == REG_DERIV_POLE) ? 32'(RST_DERIV_POLE)
                                                 : 32'(RST_TRACKING_GAIN);
                default: val = $urandom_range(0, 1 << FRAC);
            endcase
            return {junk[CFG_DATA_BITS-1:UCOEF_BITS], val[UCOEF_BITS-1:0]};
        end
        case (pick)
            0: val = 32'h8000_0000;
            1: val = 32'h7FFF_FFFF;
            2: val = '0;
            3, 4: begin
                case (idx)
                    REG_GAIN_K:          val = RST_GAIN_K;
                    REG_SETPOINT_WEIGHT: val = RST_SETPOINT_WEIGHT;
                    REG_DERIV_GAIN:      val = RST_DERIV_GAIN;
                    default:             val = RST_INTEGRAL_GAIN;
                endcase
            end
            8: val = $urandom;
            default: val = $urandom_range(0, 1 << 26) - (1 << 25);
        endcase
        return val;
    endfunction

    function automatic void row_write(logic [CFG_ADDR_BITS-1:0] a,
                                      logic [CFG_DATA_BITS-1:0] d);
        t_row row;
        row.kind = ROW_WRITE;
        row.addr = a;
        row.data = d;
        dir_rows.push_back(row);
    endfunction

    function automatic void row_sample(int m, int r, int u, bit c,
                                       bit typed = 1'b0, t_ctrl_result want = '0);
        t_row row;
        row.kind      = ROW_SAMPLE;
        row.smp.meas  = t_sample16'(m);
        row.smp.refv  = t_sample16'(r);
        row.smp.drive = t_sample16'(u);
        row.smp.clr   = c;
        row.typed     = typed;
        row.want      = want;
        dir_rows.push_back(row);
    endfunction

    task automatic report_error(string msg);
        if (error_count < MAX_PRINTS) $display("ERROR: %s", msg);
        error_count++;
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (ctrl_outputs_due.size() != 0) @(posedge i_clk);
        repeat (IDLE_CYCLES) @(posedge i_clk);
    endtask

    // Leaves the write enable high so back-to-back writes need no toggle;
    // the next sample lowers it.
    task automatic cfg_write(logic [CFG_ADDR_BITS-1:0] a, logic [CFG_DATA_BITS-1:0] d);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= a;
        i_cfg_data <= d;
        cfg_model(a, d);
        @(posedge i_clk);
        cfg_open = 1'b1;
    endtask

    task automatic send_sample(t_sample s, bit typed = 1'b0, t_ctrl_result want = '0);
        int           gap;
        t_ctrl_result predicted;
        gap = $urandom_range(0, src_gap_max);
        if (cfg_open) begin
            i_cfg_we <= 1'b0;
            cfg_open = 1'b0;
        end
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {s.drive, s.refv, s.meas};
        s_axis_tuser  <= s.clr;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predicted = pid_update(s);
        ctrl_outputs_due.push_back(typed ? want : predicted);
    endtask

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    // Output side: random stalls, and two long hold-offs that back the
    // block up until it refuses input.
    initial begin
        int           gap;
        t_ctrl_result got;
        t_ctrl_result exp_res;
        forever begin
            if (words_seen == 300 || words_seen == 1100) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            gap = $urandom_range(0, snk_gap_max);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!(m_axis_tvalid && i_rst_n)) @(posedge i_clk);
            got.ctrl = m_axis_tdata[SAMPLE_BITS-1:0];
            got.sat  = m_axis_tuser[0];
            if (ctrl_outputs_due.size() == 0) begin
                report_error($sformatf("word %0d arrived with none expected", words_seen));
            end else begin
                exp_res = ctrl_outputs_due.pop_front();
                if (got.ctrl !== exp_res.ctrl)
                    report_error($sformatf("word %0d control_out got %0d expected %0d",
                                           words_seen, $signed(got.ctrl),
                                           $signed(exp_res.ctrl)));
                if (got.sat !== exp_res.sat)
                    report_error($sformatf("word %0d out_saturated got %0b expected %0b",
                                           words_seen, got.sat, exp_res.sat));
            end
            words_seen++;
        end
    end

    initial begin
        // Defaults after reset, then saturating steps of the input range.
        row_sample(0, 0, 0, 1'b0, 1'b1, '{ctrl: '0, sat: 1'b0});
        row_sample(S_MIN, S_MAX, 0, 1'b0, 1'b1, '{ctrl: SAMPLE_MIN, sat: 1'b1});
        row_sample(S_MAX, S_MIN, 0, 1'b0, 1'b1, '{ctrl: SAMPLE_MAX, sat: 1'b1});
        row_sample(1234, -567, S_MAX, 1'b0);
        row_sample(-1, -1, S_MIN, 1'b1);
        // Integrator on, set with junk above the register width.
        row_write(REG_INTEGRATOR_ENABLE, 32'hFFFF_FFFF);
        row_write(REG_UNUSED, 32'hFFFF_FFFF);
        row_sample(1000, 3000, S_MIN, 1'b0);
        row_sample(1000, 3000, S_MAX, 1'b0);
        row_sample(500, -500, 0, 1'b1);
        row_sample(S_MIN, S_MIN, S_MIN, 1'b0);
        row_sample(S_MAX, S_MAX, S_MAX, 1'b0);
        // Every coefficient at an extreme, so the wide state saturates.
        row_write(REG_GAIN_K, 32'h7FFF_FFFF);
        row_write(REG_SETPOINT_WEIGHT, 32'h8000_0000);
        row_write(REG_DERIV_POLE, 32'hFFFF_FFFF);
        row_write(REG_DERIV_GAIN, 32'h7FFF_FFFF);
        row_write(REG_INTEGRAL_GAIN, 32'h8000_0000);
        row_write(REG_TRACKING_GAIN, 32'hFFFF_FFFF);
        row_sample(S_MAX, S_MIN, S_MIN, 1'b0);
        row_sample(S_MIN, S_MAX, S_MAX, 1'b0);
        row_sample(0, 0, 0, 1'b0);
        row_sample(0, 0, 0, 1'b0);
        row_write(REG_GAIN_K, 32'h8000_0000);
        row_write(REG_SETPOINT_WEIGHT, 32'h7FFF_FFFF);
        row_write(REG_DERIV_POLE, 32'h0000_0000);
        row_write(REG_DERIV_GAIN, 32'h8000_0000);
        row_write(REG_INTEGRAL_GAIN, 32'h7FFF_FFFF);
        row_write(REG_TRACKING_GAIN, 32'h0000_0000);
        row_sample(S_MIN, S_MAX, 0, 1'b0);
        row_sample(S_MAX, S_MIN, S_MAX, 1'b0);
        row_sample(-300, 200, -100, 1'b0);
        row_sample(0, 0, 0, 1'b1);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_WRITE) begin
                if (!cfg_open) wait_idle();
                cfg_write(dir_rows[i].addr, dir_rows[i].data);
            end else begin
                send_sample(dir_rows[i].smp, dir_rows[i].typed, dir_rows[i].want);
            end
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            wait_idle();
            src_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
            snk_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
            act_lim     = $urandom_range(100, S_MAX);
            for (int idx = REG_GAIN_K; idx <= REG_INTEGRATOR_ENABLE; idx++)
                cfg_write(CFG_ADDR_BITS'(idx), cfg_pick(CFG_ADDR_BITS'(idx)));
            if ($urandom_range(0, 2) == 0) cfg_write(REG_UNUSED, $urandom);
            repeat (PHASE_WORDS) send_sample(next_sample());
        end

        wait_idle();
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
